### rtl/core/smsprng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled minimal standard generator: shared package
// Word widths, generator constants and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package smsprng_pkg;

    localparam int WORD_W = 31;
    localparam int MUL_W  = 15;
    localparam int PROD_W = WORD_W + MUL_W;

    localparam logic [MUL_W-1:0]  MUL_A = 15'd16807;
    localparam logic [WORD_W-1:0] MOD_M = 31'h7FFF_FFFF;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic warm_fold;
        logic draw_fold;
        logic draw_commit;
    } cmd_t;

    typedef struct packed {
        logic init_needed;
        logic cnt_zero;
    } status_t;

endpackage
`default_nettype wire

### rtl/core/smsprng_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one request word: the operation and the seed for a reseed.
// ----------------------------------------------------------------------------
interface smsprng_req_if;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    smsprng_pkg::word_t   seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_value, output ready);

endinterface
`default_nettype wire

### rtl/core/smsprng_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Carries one result word: the shuffled deviate and the generator seed.
// ----------------------------------------------------------------------------
interface smsprng_rsp_if;

    logic                 valid;
    logic                 ready;
    smsprng_pkg::word_t   random_value;
    smsprng_pkg::word_t   seed_out;

    modport source (output valid, output random_value, output seed_out, input ready);
    modport sink   (input valid, input random_value, input seed_out, output ready);

endinterface
`default_nettype wire

### rtl/core/smsprng_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smsprng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/core/smsprng_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled minimal standard generator: datapath
// Seed multiplier with Mersenne fold, slot selection by reciprocal
// multiplication, warm-up counter, shuffle table and result registers.
// ----------------------------------------------------------------------------
module smsprng_datapath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire smsprng_pkg::cmd_t    cmd,
    output smsprng_pkg::status_t      status,
    input  wire logic                 operation,
    input  wire smsprng_pkg::word_t   seed_value,
    output smsprng_pkg::word_t        random_value,
    output smsprng_pkg::word_t        seed_out
);

    import smsprng_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 8);
    localparam int QP_W   = 2 * WORD_W + 1;

    localparam longint unsigned NDIV =
        64'd1 + (64'(MOD_M) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam int SH    = $clog2(NDIV);
    localparam int SHIFT = WORD_W + SH;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + NDIV - 64'd1) / NDIV;
    localparam logic [WORD_W:0] RECIP = (WORD_W + 1)'(RECIP_L);

    word_t               seed_reg, seed_next;
    word_t               held_reg, held_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [QP_W-1:0]     qprod_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   slot_reg;
    word_t               rand_reg;
    word_t               sout_reg;

    logic [WORD_W:0]     fold_sum;
    word_t               fold_val;
    logic [QP_W-1:0]     quot;
    logic [ADDR_W-1:0]   slot;
    word_t               start_seed;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    word_t               ram_wdata;
    word_t               ram_rdata;

    always_comb
    begin
        fold_sum = (WORD_W + 1)'(prod_reg[PROD_W-1:WORD_W]) + {1'b0, prod_reg[WORD_W-1:0]};
        if (fold_sum >= {1'b0, MOD_M})
        begin
            fold_sum = fold_sum - {1'b0, MOD_M};
        end
        fold_val = fold_sum[WORD_W-1:0];
    end

    always_comb
    begin
        quot = qprod_reg >> SHIFT;
        if (quot >= QP_W'(TABLE_ENTRIES))
        begin
            slot = ADDR_W'(TABLE_ENTRIES - 1);
        end
        else
        begin
            slot = quot[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        if (operation && seed_value != '0)
        begin
            start_seed = seed_value;
        end
        else
        begin
            start_seed = WORD_W'(1);
        end
        status.init_needed = operation || (held_reg == '0) || (seed_reg == '0);
        status.cnt_zero    = (cnt_reg == '0);
    end

    always_comb
    begin
        seed_next = seed_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = seed_reg;
        if (cmd.accept && status.init_needed)
        begin
            seed_next = start_seed;
            cnt_next  = CNT_W'(TABLE_ENTRIES + 7);
        end
        if (cmd.warm_fold)
        begin
            seed_next = fold_val;
            ram_waddr = cnt_reg[ADDR_W-1:0];
            ram_wdata = fold_val;
            ram_we    = (cnt_reg < CNT_W'(TABLE_ENTRIES));
            if (cnt_reg == '0)
            begin
                held_next = fold_val;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        if (cmd.draw_fold)
        begin
            seed_next = fold_val;
        end
        if (cmd.draw_commit)
        begin
            held_next = ram_rdata;
            ram_we    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= WORD_W'(1);
            held_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.mul)
        begin
            prod_reg  <= PROD_W'(seed_reg) * PROD_W'(MUL_A);
            qprod_reg <= QP_W'(held_reg) * QP_W'(RECIP);
        end
        if (cmd.draw_fold)
        begin
            slot_reg <= slot;
        end
        if (cmd.draw_commit)
        begin
            rand_reg <= ram_rdata;
            sout_reg <= seed_reg;
        end
    end

    smsprng_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign random_value = rand_reg;
    assign seed_out     = sout_reg;

endmodule
`default_nettype wire

### rtl/core/smsprng_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled minimal standard generator: controller
// Sequences warm-up and draw steps and owns both channel handshakes.
// ----------------------------------------------------------------------------
module smsprng_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output smsprng_pkg::cmd_t           cmd,
    input  wire smsprng_pkg::status_t   status
);

    import smsprng_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WMUL   = 3'd1;
    localparam logic [2:0] ST_WFOLD  = 3'd2;
    localparam logic [2:0] ST_DMUL   = 3'd3;
    localparam logic [2:0] ST_DFOLD  = 3'd4;
    localparam logic [2:0] ST_DWRITE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.init_needed ? ST_WMUL : ST_DMUL;
                end
            end
            ST_WMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WFOLD;
            end
            ST_WFOLD:
            begin
                cmd.warm_fold = 1'b1;
                state_next    = status.cnt_zero ? ST_DMUL : ST_WMUL;
            end
            ST_DMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DFOLD;
            end
            ST_DFOLD:
            begin
                cmd.draw_fold = 1'b1;
                state_next    = ST_DWRITE;
            end
            ST_DWRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.draw_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.draw_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### rtl/core/shuffled_minimal_standard_prng_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled minimal standard generator
// Multiplier-16807 congruential generator modulo 2^31-1 behind a shuffle table.
// ----------------------------------------------------------------------------
// A request word carries an operation (draw, or reseed then draw) and a seed.
// Each request gives exactly one result word: the shuffled deviate, whose
// uniform fraction is the value divided by 2^31-1, and the generator seed.
// A plain draw runs from acceptance through the seed and slot multipliers,
// then the modular fold and table read, then the table write and result
// register load; the next request is taken only after that write.
// A reseed, or a draw while the held output or the seed is zero, first runs
// TABLE_ENTRIES+8 generator steps through the same multiplier and fold.
// After reset the seed is 1 and the held output is zero, so the first draw
// initialises the table; the table itself is not cleared.
// The result register holds a word until it is taken; a new request is
// accepted meanwhile, and the block waits before its own result only while
// the previous one is still held.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    smsprng_req_if.sink   request,
    smsprng_rsp_if.source result
);

    import smsprng_pkg::*;

    cmd_t    cmd;
    status_t status;

    smsprng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    smsprng_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (request.operation),
        .seed_value   (request.seed_value),
        .random_value (result.random_value),
        .seed_out     (result.seed_out)
    );

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shuffled minimal standard generator: testbench
// Feeds draw and reseed words through the request channel and checks every
// result word against an independent model of the generator and its shuffle
// table, or a fixed expected value. A short directed table covers the seed
// extremes and the zero-seed reinitialisation, then a long random run follows,
// with random gaps and stalls on both channels and one stretch with none.
// ----------------------------------------------------------------------------
module tb;

    import smsprng_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 450;
    localparam int IDLE_PCT      = 23;
    localparam int QUIET_FIRST   = 180;
    localparam int QUIET_LAST    = 300;
    localparam int DRAIN_CYCLES  = 150;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic [63:0] SCH_Q = 64'd127773;
    localparam logic [63:0] SCH_R = 64'd2836;
    localparam word_t SLOT_DIV =
        word_t'(32'd1 + (32'(MOD_M) - 32'd1) / 32'(TABLE_ENTRIES));

    typedef struct packed {
        logic  op;
        word_t seed;
        logic  fixed;
        word_t fixed_value;
        word_t fixed_seed;
    } stim_t;

    typedef struct packed {
        word_t value;
        word_t seed;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n;

    smsprng_req_if request ();
    smsprng_rsp_if result ();

    shuffled_minimal_standard_prng_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .result (result)
    );

    stim_t directed_tbl [0:20];
    stim_t stim_q [$];
    draw_t expected_draws [$];

    word_t gen_seed = word_t'(1);
    word_t held_val = '0;
    word_t shuffle_tbl [TABLE_ENTRIES];

    int send_idx = 0;
    int cycles   = 0;
    int errors   = 0;
    int checked  = 0;
    int reseeds  = 0;
    int reinits  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic word_t ms_step(word_t s);
        logic [63:0] k;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        k  = {33'd0, s} / SCH_Q;
        hi = 64'd16807 * ({33'd0, s} - k * SCH_Q);
        lo = SCH_R * k;
        if (hi >= lo)
            r = hi - lo;
        else
            r = hi + {33'd0, MOD_M} - lo;
        return r[WORD_W-1:0];
    endfunction

    task automatic warm_table(word_t start);
        word_t s;
        s = start;
        for (int j = TABLE_ENTRIES + 7; j >= 0; j--)
        begin
            s = ms_step(s);
            if (j < TABLE_ENTRIES)
                shuffle_tbl[j] = s;
        end
        gen_seed = s;
        held_val = shuffle_tbl[0];
        reinits++;
    endtask

    task automatic record_draw(stim_t w);
        int    slot;
        draw_t d;
        if (w.op == OP_RESEED)
        begin
            reseeds++;
            warm_table(w.seed == '0 ? word_t'(1) : w.seed);
        end
        else if (held_val == '0 || gen_seed == '0)
            warm_table(word_t'(1));
        gen_seed = ms_step(gen_seed);
        slot = int'(held_val / SLOT_DIV);
        if (slot >= TABLE_ENTRIES)
            slot = TABLE_ENTRIES - 1;
        held_val = shuffle_tbl[slot];
        shuffle_tbl[slot] = gen_seed;
        if (w.fixed)
        begin
            d.value = w.fixed_value;
            d.seed  = w.fixed_seed;
        end
        else
        begin
            d.value = held_val;
            d.seed  = gen_seed;
        end
        expected_draws.push_back(d);
    endtask

    function automatic logic quiet_stretch();
        return send_idx >= QUIET_FIRST && send_idx < QUIET_LAST;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            request.valid      <= 1'b0;
            request.operation  <= OP_DRAW;
            request.seed_value <= '0;
        end
        else
        begin
            if (request.valid && request.ready)
            begin
                record_draw(stim_q[send_idx]);
                send_idx++;
            end
            if (!request.valid || request.ready)
            begin
                if (send_idx < stim_q.size()
                    && (quiet_stretch() || $urandom_range(99) >= IDLE_PCT))
                begin
                    request.valid      <= 1'b1;
                    request.operation  <= stim_q[send_idx].op;
                    request.seed_value <= stim_q[send_idx].seed;
                end
                else
                    request.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge clk)
    begin
        draw_t d;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result word value %h seed %h",
                         $time, result.random_value, result.seed_out);
                errors++;
            end
            else
            begin
                d = expected_draws.pop_front();
                checked++;
                if (result.random_value !== d.value)
                begin
                    $display("%0t: random_value expected %h actual %h",
                             $time, d.value, result.random_value);
                    errors++;
                end
                if (result.seed_out !== d.seed)
                begin
                    $display("%0t: seed_out expected %h actual %h",
                             $time, d.seed, result.seed_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, expected_draws.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        stim_t w;
        int    pick;
        rst_n = 1'b0;

        directed_tbl = '{
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   MOD_M,          1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd1,          1'b0, 31'd0, 31'd0},
            '{OP_RESEED, MOD_M,          1'b1, 31'd0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_RESEED, MOD_M - 31'd1,  1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd127773,     1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd127772,     1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd2836,       1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'd16807,      1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'h2AAA_AAAA,  1'b0, 31'd0, 31'd0},
            '{OP_RESEED, 31'h5555_5555,  1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   31'h2AAA_AAAA,  1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   31'h5555_5555,  1'b0, 31'd0, 31'd0},
            '{OP_RESEED, MOD_M,          1'b1, 31'd0, 31'd0},
            '{OP_RESEED, MOD_M,          1'b1, 31'd0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0, 31'd0}
        };
        foreach (directed_tbl[i])
            stim_q.push_back(directed_tbl[i]);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w       = '0;
            w.op    = ($urandom_range(99) < 8) ? OP_RESEED : OP_DRAW;
            pick    = $urandom_range(9);
            case (pick)
                0:       w.seed = '0;
                1:       w.seed = word_t'(1);
                2:       w.seed = MOD_M;
                3:       w.seed = MOD_M - 31'd1;
                default: w.seed = word_t'($urandom);
            endcase
            stim_q.push_back(w);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (send_idx == stim_q.size() && expected_draws.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d reseeds), %0d table initialisations modelled.",
                 send_idx, reseeds, reinits);
        $display("Checked %0d result words in %0d cycles, %0d mismatches.",
                 checked, cycles, errors);
        if (errors == 0 && expected_draws.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
